/* rtl/core/mtt_pkg.sv */
`default_nettype none

package mtt_pkg;

  // Bank sizes and timebase
  localparam int NUM_PERIODIC  = 8;
  localparam int NUM_DELAYS    = 8;
  localparam int MS_PER_SECOND = 1000;

  // Field widths of the item formats
  localparam int CMD_W   = 3;
  localparam int SLOT_W  = 3;
  localparam int VALUE_W = 16;
  localparam int GIVEN_W = 3;
  localparam int SEC_W   = 16;

  // Derived widths
  localparam int PIDX_W = (NUM_PERIODIC > 1) ? $clog2(NUM_PERIODIC) : 1;
  localparam int DIDX_W = (NUM_DELAYS > 1) ? $clog2(NUM_DELAYS) : 1;
  localparam int CNT_W  = $clog2(NUM_PERIODIC + 1);
  localparam int WALK_N = (NUM_PERIODIC > NUM_DELAYS) ? NUM_PERIODIC : NUM_DELAYS;
  localparam int WALK_W = (WALK_N > 1) ? $clog2(WALK_N) : 1;
  localparam int MS_W   = $clog2(MS_PER_SECOND);
  // Common compare width for slot, walk index and channel count
  localparam int WIDE_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_ADD_PERIOD = 3'd1,
    CMD_SET_ENABLE = 3'd2,
    CMD_START_DLY  = 3'd3,
    CMD_TEST_TIMER = 3'd4,
    CMD_TEST_DLY   = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
    logic               enable;
  } item_in_t;

  typedef struct packed {
    logic               ok;
    logic               flag;
    logic [GIVEN_W-1:0] given_slot;
    logic [SEC_W-1:0]   seconds;
  } item_out_t;

  // Controller to datapath
  typedef struct packed {
    logic              cap_in;
    logic              exec;
    logic              walk;
    logic [WALK_W-1:0] walk_idx;
    logic              load_out;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic is_tick;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/mtt_dp.sv */
`default_nettype none

module mtt_dp (
  input  wire                   clk,
  input  wire                   rst_n,
  input  mtt_pkg::item_in_t     in_item,
  input  mtt_pkg::ctl_t         ctl,
  output mtt_pkg::sts_t         sts,
  output mtt_pkg::item_out_t    out_item
);
  import mtt_pkg::*;

  item_in_t           item_r;
  logic [VALUE_W-1:0] reload_r  [NUM_PERIODIC];
  logic [VALUE_W-1:0] remain_r  [NUM_PERIODIC];
  logic [VALUE_W-1:0] dremain_r [NUM_DELAYS];
  logic [NUM_PERIODIC-1:0] active_r, active_nxt;
  logic [NUM_PERIODIC-1:0] fired_r, fired_nxt;
  logic [NUM_DELAYS-1:0]   busy_r, busy_nxt;
  logic [NUM_DELAYS-1:0]   done_r, done_nxt;
  logic [CNT_W-1:0]   pcount_r, pcount_nxt;
  logic [MS_W-1:0]    milli_r, milli_nxt;
  logic [SEC_W-1:0]   sec_r, sec_nxt;
  logic               ok_r;
  logic               flag_r;
  logic [GIVEN_W-1:0] given_r;
  item_out_t          out_r;

  logic [WIDE_W-1:0]  slot_w, cnt_w, walk_w;
  logic [PIDX_W-1:0]  pidx, wpidx;
  logic [DIDX_W-1:0]  didx, wdidx, fidx;
  logic               found, val_nz, p_room, p_slot_ok, d_slot_ok;
  logic               do_tick, do_add, do_en, do_dly, do_tst, do_tsd;
  logic               w_p_live, w_d_live;
  logic [VALUE_W-1:0] p_dec, d_dec;
  logic               res_ok, res_flag;
  logic [GIVEN_W-1:0] res_given;

  assign slot_w = WIDE_W'(item_r.slot);
  assign cnt_w  = WIDE_W'(pcount_r);
  assign walk_w = WIDE_W'(ctl.walk_idx);
  assign pidx   = slot_w[PIDX_W-1:0];
  assign didx   = slot_w[DIDX_W-1:0];
  assign wpidx  = walk_w[PIDX_W-1:0];
  assign wdidx  = walk_w[DIDX_W-1:0];

  assign val_nz    = (item_r.value != '0);
  assign p_room    = (cnt_w < WIDE_W'(NUM_PERIODIC));
  assign p_slot_ok = (slot_w < cnt_w) && (slot_w < WIDE_W'(NUM_PERIODIC));
  assign d_slot_ok = (slot_w < WIDE_W'(NUM_DELAYS));

  // First free delay slot, lowest index wins
  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int i = NUM_DELAYS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        found = 1'b1;
        fidx  = DIDX_W'(i);
      end
    end
  end

  assign do_tick = ctl.exec && (item_r.cmd == CMD_TICK);
  assign do_add  = ctl.exec && (item_r.cmd == CMD_ADD_PERIOD) && val_nz && p_room;
  assign do_en   = ctl.exec && (item_r.cmd == CMD_SET_ENABLE) && p_slot_ok;
  assign do_dly  = ctl.exec && (item_r.cmd == CMD_START_DLY) && val_nz && found;
  assign do_tst  = ctl.exec && (item_r.cmd == CMD_TEST_TIMER) && p_slot_ok;
  assign do_tsd  = ctl.exec && (item_r.cmd == CMD_TEST_DLY) && d_slot_ok;

  // One periodic channel and one delay slot per walk step
  assign w_p_live = ctl.walk && (walk_w < cnt_w) && (walk_w < WIDE_W'(NUM_PERIODIC)) &&
                    active_r[wpidx] && (remain_r[wpidx] != '0);
  assign w_d_live = ctl.walk && (walk_w < WIDE_W'(NUM_DELAYS)) &&
                    busy_r[wdidx] && (dremain_r[wdidx] != '0);
  assign p_dec = remain_r[wpidx] - VALUE_W'(1);
  assign d_dec = dremain_r[wdidx] - VALUE_W'(1);

  always_comb begin
    res_ok    = do_tick || do_add || do_en || do_dly || do_tst || do_tsd;
    res_flag  = 1'b0;
    res_given = '0;
    if (do_add) begin
      res_given = cnt_w[GIVEN_W-1:0];
    end
    if (do_dly) begin
      res_given = GIVEN_W'(fidx);
    end
    if (do_tst) begin
      res_flag = fired_r[pidx];
    end
    if (do_tsd) begin
      res_flag = done_r[didx];
    end
  end

  always_comb begin
    active_nxt = active_r;
    fired_nxt  = fired_r;
    busy_nxt   = busy_r;
    done_nxt   = done_r;
    pcount_nxt = pcount_r;
    milli_nxt  = milli_r;
    sec_nxt    = sec_r;
    if (do_tick) begin
      if (milli_r == MS_W'(MS_PER_SECOND - 1)) begin
        milli_nxt = '0;
        sec_nxt   = sec_r + SEC_W'(1);
      end else begin
        milli_nxt = milli_r + MS_W'(1);
      end
    end
    if (do_add) begin
      active_nxt[cnt_w[PIDX_W-1:0]] = item_r.enable;
      fired_nxt[cnt_w[PIDX_W-1:0]]  = 1'b0;
      pcount_nxt = pcount_r + CNT_W'(1);
    end
    if (do_en) begin
      active_nxt[pidx] = item_r.enable;
    end
    if (do_dly) begin
      busy_nxt[fidx] = 1'b1;
      done_nxt[fidx] = 1'b0;
    end
    if (do_tst) begin
      fired_nxt[pidx] = 1'b0;
    end
    if (do_tsd) begin
      done_nxt[didx] = 1'b0;
    end
    if (w_p_live && (p_dec == '0)) begin
      fired_nxt[wpidx] = 1'b1;
    end
    if (w_d_live && (d_dec == '0)) begin
      done_nxt[wdidx] = 1'b1;
      busy_nxt[wdidx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      fired_r  <= '0;
      busy_r   <= '0;
      done_r   <= '0;
      pcount_r <= '0;
      milli_r  <= '0;
      sec_r    <= '0;
    end else begin
      active_r <= active_nxt;
      fired_r  <= fired_nxt;
      busy_r   <= busy_nxt;
      done_r   <= done_nxt;
      pcount_r <= pcount_nxt;
      milli_r  <= milli_nxt;
      sec_r    <= sec_nxt;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk) begin
    if (ctl.cap_in) begin
      item_r <= in_item;
    end
    if (ctl.exec) begin
      ok_r    <= res_ok;
      flag_r  <= res_flag;
      given_r <= res_given;
    end
    if (do_add) begin
      reload_r[cnt_w[PIDX_W-1:0]] <= item_r.value;
      remain_r[cnt_w[PIDX_W-1:0]] <= item_r.value;
    end
    if (do_dly) begin
      dremain_r[fidx] <= item_r.value;
    end
    if (w_p_live) begin
      remain_r[wpidx] <= (p_dec == '0) ? reload_r[wpidx] : p_dec;
    end
    if (w_d_live) begin
      dremain_r[wdidx] <= d_dec;
    end
    if (ctl.load_out) begin
      out_r.ok         <= ok_r;
      out_r.flag       <= flag_r;
      out_r.given_slot <= given_r;
      out_r.seconds    <= sec_r;
    end
  end

  assign sts.is_tick = (item_r.cmd == CMD_TICK);
  assign out_item    = out_r;

endmodule

`default_nettype wire

/* rtl/core/mtt_ctrl.sv */
`default_nettype none

module mtt_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire            out_ready,
  input  mtt_pkg::sts_t  sts,
  output mtt_pkg::ctl_t  ctl
);
  import mtt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_WALK   = 4'b0100,
    S_PEND   = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [WALK_W-1:0] walk_r, walk_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              walk_last;

  assign in_ready  = (state_r == S_IDLE);
  assign walk_last = (walk_r == WALK_W'(WALK_N - 1));

  always_comb begin
    state_nxt    = state_r;
    walk_nxt     = walk_r;
    ctl.cap_in   = 1'b0;
    ctl.exec     = 1'b0;
    ctl.walk     = 1'b0;
    ctl.walk_idx = walk_r;
    ctl.load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.cap_in = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.exec = 1'b1;
        walk_nxt = '0;
        state_nxt = sts.is_tick ? S_WALK : S_PEND;
      end
      S_WALK: begin
        ctl.walk = 1'b1;
        walk_nxt = walk_r + WALK_W'(1);
        if (walk_last) begin
          state_nxt = S_PEND;
        end
      end
      S_PEND: begin
        if (!out_valid_r || out_ready) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state lost one-hot encoding");

  a_load_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while still held");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted item not decoded next cycle");

  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_WALK) |-> (walk_r == '0))
    else $error("tick walk did not start at slot zero");

endmodule

`default_nettype wire

/* rtl/core/ms_tick_timer_bank_unit.sv */
// Millisecond timer bank: periodic channels, one-shot delay slots and a
// wrapping seconds count, driven by a command item stream.
// Input channel: in_valid / in_ready / in_item. Each item carries a command
// (tick, add periodic, set enable, start delay, test timer, test delay).
// Output channel: out_valid / out_ready / out_item. Every command returns
// exactly one result item with ok, flag, given_slot and the seconds count.
// Order: a non-tick command passes the accept, decode and load steps before
// out_valid rises; a tick also passes the walk between decode and load,
// which visits one periodic channel and one delay slot per cycle.
// One item is in work at a time; the next is taken once the previous
// result sits in the output register.
// Stall: a held result stays in the output register; the next item is
// still accepted and processed, then waits until the result is taken.
// Reset (rst_n low, synchronous): all channels inactive, no slots busy,
// flags, channel count and time counters cleared, no result pending.
`default_nettype none

module ms_tick_timer_bank_unit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  mtt_pkg::item_in_t   in_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output mtt_pkg::item_out_t  out_item
);
  import mtt_pkg::*;

  // Command and status between sequencer and datapath
  ctl_t ctl;
  sts_t sts;

  mtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  mtt_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .ctl      (ctl),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
